### rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/uqd_pkg.sv
package uqd_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_PATH     = 3'd0,
        PH_QSTART   = 3'd1,
        PH_KEYSTART = 3'd2,
        PH_KEY      = 3'd3,
        PH_VALUE    = 3'd4,
        PH_PCT1     = 3'd5,
        PH_PCT2     = 3'd6
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0]             count;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        logic                         last;
    } t_result;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

### rtl/uqd_step.sv
module uqd_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char_in,
    input  logic               i_end_of_url,
    output uqd_pkg::t_result   o_result
);

    uqd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;
    logic            w_end;
    logic [7:0]      w_dec;

    assign w_end = i_end_of_url || (i_char_in == uqd_pkg::CH_NUL);

    always_comb begin
        w_dec = {uqd_pkg::hex_val(r_held), uqd_pkg::hex_val(i_char_in)};
        if (w_dec == uqd_pkg::CH_NUL) begin
            w_dec = uqd_pkg::CH_PCT;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (w_end) begin
            n_phase = uqd_pkg::PH_PATH;
            n_held  = 8'h00;
        end else begin
            unique case (r_phase) inside
                uqd_pkg::PH_PATH: begin
                    if (i_char_in == uqd_pkg::CH_QMARK) n_phase = uqd_pkg::PH_QSTART;
                end
                uqd_pkg::PH_QSTART, uqd_pkg::PH_KEYSTART, uqd_pkg::PH_KEY: begin
                    n_phase = (i_char_in == uqd_pkg::CH_EQ) ? uqd_pkg::PH_VALUE
                                                            : uqd_pkg::PH_KEY;
                end
                uqd_pkg::PH_VALUE: begin
                    if (i_char_in == uqd_pkg::CH_AMP) begin
                        n_phase = uqd_pkg::PH_KEYSTART;
                    end else if (i_char_in == uqd_pkg::CH_PCT) begin
                        n_phase = uqd_pkg::PH_PCT1;
                    end
                end
                uqd_pkg::PH_PCT1: begin
                    n_held  = i_char_in;
                    n_phase = uqd_pkg::PH_PCT2;
                end
                uqd_pkg::PH_PCT2: begin
                    n_held  = 8'h00;
                    n_phase = uqd_pkg::PH_VALUE;
                end
                default: begin
                    n_phase = uqd_pkg::PH_PATH;
                    n_held  = 8'h00;
                end
            endcase
        end
    end

    always_comb begin
        o_result       = '0;
        o_result.last  = w_end;
        if (w_end) begin
            // list close: trailing separators, final zero is last entry
            unique case (r_phase)
                uqd_pkg::PH_KEY:      o_result.count = uqd_pkg::CNT_W'(3);
                uqd_pkg::PH_VALUE:    o_result.count = uqd_pkg::CNT_W'(2);
                uqd_pkg::PH_KEYSTART: o_result.count = uqd_pkg::CNT_W'(1);
                uqd_pkg::PH_PCT1: begin
                    o_result.bytes[0] = uqd_pkg::CH_PCT;
                    o_result.count    = uqd_pkg::CNT_W'(3);
                end
                uqd_pkg::PH_PCT2: begin
                    o_result.bytes[0] = uqd_pkg::CH_PCT;
                    if (r_held == uqd_pkg::CH_AMP) begin
                        o_result.count = uqd_pkg::CNT_W'(3);
                    end else begin
                        o_result.bytes[1] = (r_held == uqd_pkg::CH_PLUS) ? uqd_pkg::CH_SPACE
                                                                         : r_held;
                        o_result.count    = uqd_pkg::CNT_W'(4);
                    end
                end
                default:              o_result.count = uqd_pkg::CNT_W'(2);
            endcase
        end else begin
            unique case (r_phase) inside
                uqd_pkg::PH_QSTART, uqd_pkg::PH_KEYSTART, uqd_pkg::PH_KEY: begin
                    o_result.count    = uqd_pkg::CNT_W'(1);
                    o_result.bytes[0] = (i_char_in == uqd_pkg::CH_EQ) ? uqd_pkg::CH_NUL
                                                                      : i_char_in;
                end
                uqd_pkg::PH_VALUE: begin
                    if (i_char_in == uqd_pkg::CH_AMP) begin
                        o_result.count = uqd_pkg::CNT_W'(1);
                    end else if (i_char_in == uqd_pkg::CH_PLUS) begin
                        o_result.count    = uqd_pkg::CNT_W'(1);
                        o_result.bytes[0] = uqd_pkg::CH_SPACE;
                    end else if (i_char_in != uqd_pkg::CH_PCT) begin
                        o_result.count    = uqd_pkg::CNT_W'(1);
                        o_result.bytes[0] = i_char_in;
                    end
                end
                uqd_pkg::PH_PCT2: begin
                    o_result.count    = uqd_pkg::CNT_W'(1);
                    o_result.bytes[0] = w_dec;
                end
                default: o_result.count = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uqd_pkg::PH_PATH;
            r_held  <= 8'h00;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### rtl/uqd_out.sv
`include "assert_macros.svh"

module uqd_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  uqd_pkg::t_result   i_result,
    input  logic               i_out_ready,
    output logic               o_room,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_list
);

    logic [uqd_pkg::CNT_W-1:0]              r_left;
    logic [uqd_pkg::MAX_RESULTS-1:0][7:0]   r_buf;
    logic                                   r_last;
    logic                                   w_pop;

    assign o_out_valid    = (r_left != '0);
    assign w_pop          = o_out_valid && i_out_ready;
    assign o_room         = (r_left == '0) || ((r_left == uqd_pkg::CNT_W'(1)) && i_out_ready);
    assign o_out_byte     = r_buf[0];
    assign o_last_of_list = r_last && (r_left == uqd_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_result.count;
        end else if (w_pop) begin
            r_left <= r_left - uqd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf  <= i_result.bytes;
            r_last <= i_result.last;
        end else if (w_pop) begin
            r_buf <= {8'h00, r_buf[uqd_pkg::MAX_RESULTS-1:1]};
        end
    end

    `ASSERT_ALWAYS(a_left_max, i_clk, i_rst_n, r_left <= uqd_pkg::CNT_W'(uqd_pkg::MAX_RESULTS))
    `ASSERT_IMPLIES(a_last_zero, i_clk, i_rst_n, o_last_of_list, o_out_byte == uqd_pkg::CH_NUL)
    `ASSERT_IMPLIES(a_no_overrun, i_clk, i_rst_n, i_load, r_left <= uqd_pkg::CNT_W'(1))
    `ASSERT_NEXT(a_pop_step, i_clk, i_rst_n, w_pop && !i_load,
                 r_left == $past(r_left) - uqd_pkg::CNT_W'(1))

endmodule

### rtl/url_query_string_decoder.sv
// URL query string decoder.
// Input channel (i_in_valid / o_in_ready): one URL character per item in
// i_char_in; i_end_of_url (or a zero character) closes the URL.
// Output channel (o_out_valid / i_out_ready): the query as key, 0, value, 0
// pairs and one final 0 flagged by o_last_of_list.
// Results of an item are registered and appear on the output in the cycle
// after it is accepted, one byte per cycle while the receiver is ready.
// The decoder takes one item per cycle while each item gives at most one
// byte and the receiver is ready. An item that gives more bytes (up to 4,
// only at the end of a URL) holds the input until the four-entry output
// buffer is taking its last byte; it drains one byte per cycle while the receiver is ready.
// A new item is taken in the same cycle the last buffered byte is taken.
// When the receiver stalls, the output byte holds and o_in_ready drops as
// soon as the buffer holds a byte that is not being taken.
// Reset (synchronous, active low) empties the buffer and returns the parser
// to the path phase.
module url_query_string_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_url,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_list
);

    uqd_pkg::t_result w_result;
    logic             w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    uqd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_char_in    (i_char_in),
        .i_end_of_url (i_end_of_url),
        .o_result     (w_result)
    );

    uqd_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_result       (w_result),
        .i_out_ready    (i_out_ready),
        .o_room         (o_in_ready),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_list (o_last_of_list)
    );

endmodule

### tb/tb_url_query_string_decoder.sv
module tb_url_query_string_decoder;

    typedef struct packed {
        logic [7:0] ch;
        logic       eou;
    } t_url_char;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_list_byte;

    localparam int RANDOM_ITEMS = 345;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 60;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_char_in    = 8'h00;
    logic       i_end_of_url = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_of_list;

    t_url_char  url_chars[$];
    t_list_byte decoded_bytes[$];

    uqd_pkg::t_phase dec_phase = uqd_pkg::PH_PATH;
    logic [7:0]      dec_held  = 8'h00;

    int  total_items = 0;
    int  in_count    = 0;
    int  mismatches  = 0;
    int  quiet_cycles = 0;
    int  hold_cnt    = 0;
    bit  hold_done   = 1'b0;
    bit  tx_offer;

    url_query_string_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .i_end_of_url   (i_end_of_url),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_list (o_last_of_list)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int tx_idle_pct();
        if (in_count < total_items / 3) begin
            return 22;
        end else if (in_count < (2 * total_items) / 3) begin
            return 78;
        end
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (in_count < total_items / 3) begin
            return 78;
        end else if (in_count < (2 * total_items) / 3) begin
            return 22;
        end
        return 0;
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return 4'(c - 8'h61 + 8'd10);
        end
        return 4'd0;
    endfunction

    function void push_list_byte(logic [7:0] b, logic l);
        t_list_byte e;
        e.data = b;
        e.last = l;
        decoded_bytes.insert(decoded_bytes.size(), e);
    endfunction

    function void close_list();
        case (dec_phase)
            uqd_pkg::PH_KEY: begin
                push_list_byte(uqd_pkg::CH_NUL, 1'b0);
                push_list_byte(uqd_pkg::CH_NUL, 1'b0);
            end
            uqd_pkg::PH_VALUE: begin
                push_list_byte(uqd_pkg::CH_NUL, 1'b0);
            end
            uqd_pkg::PH_PCT1: begin
                push_list_byte(uqd_pkg::CH_PCT, 1'b0);
                push_list_byte(uqd_pkg::CH_NUL, 1'b0);
            end
            uqd_pkg::PH_PCT2: begin
                push_list_byte(uqd_pkg::CH_PCT, 1'b0);
                if (dec_held == uqd_pkg::CH_PLUS) begin
                    push_list_byte(uqd_pkg::CH_SPACE, 1'b0);
                end else if (dec_held != uqd_pkg::CH_AMP) begin
                    push_list_byte(dec_held, 1'b0);
                end
                push_list_byte(uqd_pkg::CH_NUL, 1'b0);
            end
            uqd_pkg::PH_KEYSTART: begin
            end
            default: begin
                push_list_byte(uqd_pkg::CH_NUL, 1'b0);
            end
        endcase
        push_list_byte(uqd_pkg::CH_NUL, 1'b1);
        dec_phase = uqd_pkg::PH_PATH;
        dec_held  = 8'h00;
    endfunction

    function void decode_char(logic [7:0] c, logic eou);
        logic [7:0] v;
        if (eou || c == uqd_pkg::CH_NUL) begin
            close_list();
            return;
        end
        case (dec_phase)
            uqd_pkg::PH_PATH: begin
                if (c == uqd_pkg::CH_QMARK) begin
                    dec_phase = uqd_pkg::PH_QSTART;
                end
            end
            uqd_pkg::PH_QSTART, uqd_pkg::PH_KEYSTART, uqd_pkg::PH_KEY: begin
                if (c == uqd_pkg::CH_EQ) begin
                    push_list_byte(uqd_pkg::CH_NUL, 1'b0);
                    dec_phase = uqd_pkg::PH_VALUE;
                end else begin
                    push_list_byte(c, 1'b0);
                    dec_phase = uqd_pkg::PH_KEY;
                end
            end
            uqd_pkg::PH_VALUE: begin
                if (c == uqd_pkg::CH_AMP) begin
                    push_list_byte(uqd_pkg::CH_NUL, 1'b0);
                    dec_phase = uqd_pkg::PH_KEYSTART;
                end else if (c == uqd_pkg::CH_PCT) begin
                    dec_phase = uqd_pkg::PH_PCT1;
                end else if (c == uqd_pkg::CH_PLUS) begin
                    push_list_byte(uqd_pkg::CH_SPACE, 1'b0);
                end else begin
                    push_list_byte(c, 1'b0);
                end
            end
            uqd_pkg::PH_PCT1: begin
                dec_held  = c;
                dec_phase = uqd_pkg::PH_PCT2;
            end
            uqd_pkg::PH_PCT2: begin
                v = {nibble_of(dec_held), nibble_of(c)};
                if (v == 8'h00) begin
                    v = uqd_pkg::CH_PCT;
                end
                push_list_byte(v, 1'b0);
                dec_held  = 8'h00;
                dec_phase = uqd_pkg::PH_VALUE;
            end
            default: begin
                dec_phase = uqd_pkg::PH_PATH;
                dec_held  = 8'h00;
            end
        endcase
    endfunction

    task automatic add_char(logic [7:0] c, logic eou = 1'b0);
        t_url_char u;
        u.ch  = c;
        u.eou = eou;
        url_chars.insert(url_chars.size(), u);
    endtask

    task automatic add_str(string s);
        for (int k = 0; k < s.len(); k++) begin
            add_char(s[k]);
        end
    endtask

    task automatic add_end();
        if ($urandom_range(9) == 0) begin
            add_char(uqd_pkg::CH_NUL);
        end else begin
            add_char(8'($urandom_range(255)), 1'b1);
        end
    endtask

    function automatic logic [7:0] hex_char();
        string hx;
        hx = "0123456789abcdefABCDEF";
        return hx[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] mixed_char();
        int r;
        r = $urandom_range(9);
        if (r < 3) begin
            case ($urandom_range(4))
                0: return uqd_pkg::CH_QMARK;
                1: return uqd_pkg::CH_EQ;
                2: return uqd_pkg::CH_AMP;
                3: return uqd_pkg::CH_PCT;
                default: return uqd_pkg::CH_PLUS;
            endcase
        end else if (r < 5) begin
            return hex_char();
        end
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic gen_url();
        int np;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(8, 1)) add_char(8'($urandom_range(255, 1)));
            add_end();
            return;
        end
        repeat ($urandom_range(4)) add_char(8'($urandom_range(255, 1)));
        if ($urandom_range(9) != 0) begin
            add_char(uqd_pkg::CH_QMARK);
        end
        np = $urandom_range(3);
        for (int p = 0; p < np; p++) begin
            repeat ($urandom_range(3)) add_char(mixed_char());
            add_char(uqd_pkg::CH_EQ);
            repeat ($urandom_range(4)) begin
                case ($urandom_range(9))
                    0, 1, 2: begin
                        add_char(uqd_pkg::CH_PCT);
                        add_char(($urandom_range(4) == 0) ? mixed_char() : hex_char());
                        add_char(($urandom_range(4) == 0) ? mixed_char() : hex_char());
                    end
                    3: add_char(uqd_pkg::CH_PLUS);
                    default: add_char(mixed_char());
                endcase
            end
            if (p < np - 1 || $urandom_range(3) == 0) begin
                add_char(uqd_pkg::CH_AMP);
            end
        end
        case ($urandom_range(9))
            0: add_char(uqd_pkg::CH_PCT);
            1: begin
                add_char(uqd_pkg::CH_PCT);
                add_char(mixed_char());
            end
            default: begin
            end
        endcase
        add_end();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            tx_offer = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                decode_char(i_char_in, i_end_of_url);
                in_count++;
                tx_offer = 1'b1;
            end
            if (tx_offer) begin
                if (url_chars.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
                    i_in_valid   <= 1'b1;
                    i_char_in    <= url_chars[0].ch;
                    i_end_of_url <= url_chars[0].eou;
                    void'(url_chars.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off late in the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && in_count >= (5 * total_items) / 6) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct());
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_list_byte e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_bytes.size() == 0) begin
                $error("unexpected item: out_byte %h last_of_list %b",
                       o_out_byte, o_last_of_list);
                mismatches++;
            end else begin
                e = decoded_bytes.pop_front();
                if (o_out_byte !== e.data) begin
                    $error("out_byte: expected %h, got %h", e.data, o_out_byte);
                    mismatches++;
                end
                if (o_last_of_list !== e.last) begin
                    $error("last_of_list: expected %b, got %b", e.last, o_last_of_list);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int directed;
        // empty URL, char_in ignored on end
        add_char(8'hFF, 1'b1);
        // zero character right after '?'
        add_str("?");
        add_char(uqd_pkg::CH_NUL);
        // end inside a key
        add_str("x?k");
        add_char(8'h00, 1'b1);
        // short escapes
        add_str("?=%");
        add_char(8'h00, 1'b1);
        add_str("?=%+");
        add_char(8'h00, 1'b1);
        add_str("?=%&");
        add_char(8'h00, 1'b1);
        add_char(uqd_pkg::CH_QMARK);
        add_char(uqd_pkg::CH_EQ);
        add_char(uqd_pkg::CH_PCT);
        add_char(8'hFF);
        add_char(8'h00, 1'b1);
        // '&' in a key, decoded zero, plus, end right after '&'
        add_str("?a&=%00+&");
        add_char(8'h00, 1'b1);
        directed = url_chars.size();
        while (url_chars.size() < directed + RANDOM_ITEMS) begin
            gen_url();
        end
        total_items = url_chars.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (url_chars.size() != 0 || i_in_valid) @(posedge i_clk);
        while (decoded_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (decoded_bytes.size() != 0) begin
            $error("%0d expected items never arrived", decoded_bytes.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/uqd_pkg.sv
rtl/uqd_step.sv
rtl/uqd_out.sv
rtl/url_query_string_decoder.sv
tb/tb_url_query_string_decoder.sv
